### hw/rtl/olst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olst_pkg
// Shared types and constants of the ordered list engine.
// ----------------------------------------------------------------------------
package olst_pkg;

    localparam int DATA_W     = 32;
    localparam int FUNC_W     = 4;
    localparam int POS_W      = 4;
    localparam int STATUS_W   = 2;
    localparam int CNT_OUT_W  = 5;
    localparam int POS_SPAN   = 1 << POS_W;
    localparam int CAPACITY   = 16;

    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH_FRONT = 4'd0,
        FN_PUSH_BACK  = 4'd1,
        FN_POP_FRONT  = 4'd2,
        FN_POP_BACK   = 4'd3,
        FN_INSERT     = 4'd4,
        FN_DELETE     = 4'd5,
        FN_REVERSE    = 4'd6,
        FN_SORT       = 4'd7,
        FN_UPDATE     = 4'd8,
        FN_SEARCH     = 4'd9,
        FN_READ       = 4'd10,
        FN_SIZE       = 4'd11
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE  = 2'd0,
        STAT_SHORT = 2'd1,
        STAT_RANGE = 2'd2,
        STAT_FULL  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INS,
        CELL_DEL,
        CELL_WR,
        CELL_XCHG
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     phase;
        logic     swap_all;
    } t_cell_ctl;

    typedef struct packed {
        t_status                    status;
        logic                       found;
        logic signed [DATA_W-1:0]   read_value;
        logic [CNT_OUT_W-1:0]       entry_count;
    } t_result;

endpackage

### hw/rtl/olst_cmd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olst_cmd_if
// Command channel: one list operation per beat.
// ----------------------------------------------------------------------------
interface olst_cmd_if;
    logic                                   valid;
    logic                                   ready;
    logic [olst_pkg::FUNC_W-1:0]            func;
    logic signed [olst_pkg::DATA_W-1:0]     value;
    logic [olst_pkg::POS_W-1:0]             position;

    modport source (output valid, output func, output value, output position, input ready);
    modport sink   (input valid, input func, input value, input position, output ready);
endinterface

### hw/rtl/olst_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olst_res_if
// Result channel: one status beat per command.
// ----------------------------------------------------------------------------
interface olst_res_if;
    logic                                   valid;
    logic                                   ready;
    logic [olst_pkg::STATUS_W-1:0]          status;
    logic                                   found;
    logic signed [olst_pkg::DATA_W-1:0]     read_value;
    logic [olst_pkg::CNT_OUT_W-1:0]         entry_count;

    modport source (output valid, output status, output found, output read_value,
                    output entry_count, input ready);
    modport sink   (input valid, input status, input found, input read_value,
                    input entry_count, output ready);
endinterface

### hw/rtl/olst_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olst_cell
// One list slot: shifts with its neighbors, writes, and does one
// compare-exchange step with a neighbor per cycle.
// ----------------------------------------------------------------------------
module olst_cell #(
    parameter int IDX = 0,
    parameter int CW  = 5
) (
    input  logic                                i_clk,
    input  olst_pkg::t_cell_ctl                 i_ctl,
    input  logic [CW-1:0]                       i_at,
    input  logic [CW-1:0]                       i_count,
    input  logic signed [olst_pkg::DATA_W-1:0]  i_value,
    input  logic signed [olst_pkg::DATA_W-1:0]  i_left,
    input  logic signed [olst_pkg::DATA_W-1:0]  i_right,
    input  logic                                i_gt_left,
    output logic signed [olst_pkg::DATA_W-1:0]  o_data,
    output logic                                o_gt,
    output logic                                o_match
);

    localparam logic [CW-1:0] IDX_C    = CW'(IDX);
    localparam logic [CW-1:0] NEXT_C   = CW'(IDX + 1);
    localparam logic          PAR      = 1'(IDX % 2);
    localparam bit            HAS_LEFT = (IDX > 0);

    logic signed [olst_pkg::DATA_W-1:0] r_data;
    logic signed [olst_pkg::DATA_W-1:0] n_data;

    assign o_data  = r_data;
    assign o_gt    = r_data > i_right;
    assign o_match = (IDX_C < i_count) && (r_data == i_value);

    always_comb begin
        n_data = r_data;
        case (i_ctl.op)
            olst_pkg::CELL_INS: begin
                if (IDX_C > i_at) begin
                    n_data = i_left;
                end else if (IDX_C == i_at) begin
                    n_data = i_value;
                end
            end
            olst_pkg::CELL_DEL: begin
                if (IDX_C >= i_at) begin
                    n_data = i_right;
                end
            end
            olst_pkg::CELL_WR: begin
                if (IDX_C == i_at) begin
                    n_data = i_value;
                end
            end
            olst_pkg::CELL_XCHG: begin
                // left member of a pair looks right, right member looks left
                if ((PAR == i_ctl.phase) && (NEXT_C < i_count)) begin
                    if (o_gt || i_ctl.swap_all) begin
                        n_data = i_right;
                    end
                end else if (HAS_LEFT && (PAR != i_ctl.phase) && (IDX_C < i_count)) begin
                    if (i_gt_left || i_ctl.swap_all) begin
                        n_data = i_left;
                    end
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

endmodule

### hw/rtl/olst_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olst_ctrl
// Command decode, entry count, transposition pass sequencer and the
// two-deep result buffer.
// ----------------------------------------------------------------------------
module olst_ctrl #(
    parameter int CAPACITY = olst_pkg::CAPACITY,
    parameter int CW       = $clog2(CAPACITY + 1)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    olst_cmd_if.sink                            i_cmd,
    olst_res_if.source                          o_res,
    input  logic signed [olst_pkg::DATA_W-1:0]  i_data [CAPACITY],
    input  logic [CAPACITY-1:0]                 i_match,
    output olst_pkg::t_cell_ctl                 o_ctl,
    output logic [CW-1:0]                       o_at,
    output logic [CW-1:0]                       o_count
);

    localparam int CMPW = (CW > olst_pkg::POS_W) ? CW : olst_pkg::POS_W;
    localparam int RD_N = (CAPACITY < olst_pkg::POS_SPAN) ? CAPACITY : olst_pkg::POS_SPAN;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    typedef enum logic {
        S_IDLE,
        S_XCHG
    } t_state;

    t_state             r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_pass, n_pass;
    logic               r_swap_all, n_swap_all;
    logic               r_out_v, r_skid_v;
    olst_pkg::t_result  r_out, r_skid;

    logic                               w_accept;
    logic                               w_pop;
    logic                               w_last;
    logic                               w_empty;
    logic                               w_full;
    logic                               w_pos_ge;
    logic signed [olst_pkg::DATA_W-1:0] w_rd;
    logic                               w_push;
    olst_pkg::t_result                  w_res;
    olst_pkg::t_cell_ctl                w_ctl;
    logic [CW-1:0]                      w_at;

    assign i_cmd.ready = (r_state == S_IDLE) && !r_skid_v;
    assign w_accept    = i_cmd.valid && i_cmd.ready;
    assign w_pop       = r_out_v && o_res.ready;
    assign w_last      = r_pass == (r_count - CW'(1));
    assign w_empty     = r_count == '0;
    assign w_full      = r_count >= CAP_C;
    assign w_pos_ge    = CMPW'(i_cmd.position) >= CMPW'(r_count);

    assign o_res.valid       = r_out_v;
    assign o_res.status      = r_out.status;
    assign o_res.found       = r_out.found;
    assign o_res.read_value  = r_out.read_value;
    assign o_res.entry_count = r_out.entry_count;

    assign o_ctl   = w_ctl;
    assign o_at    = w_at;
    assign o_count = r_count;

    always_comb begin
        w_rd = '0;
        for (int k = 0; k < RD_N; k++) begin
            if (i_cmd.position == olst_pkg::POS_W'(k)) begin
                w_rd = i_data[k];
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_pass     = r_pass;
        n_swap_all = r_swap_all;
        w_ctl      = '{op: olst_pkg::CELL_HOLD, phase: 1'b0, swap_all: 1'b0};
        w_at       = CW'(i_cmd.position);
        w_push     = 1'b0;
        w_res      = '{status: olst_pkg::STAT_DONE, found: 1'b0, read_value: '0,
                       entry_count: '0};
        if (r_state == S_XCHG) begin
            w_ctl.op       = olst_pkg::CELL_XCHG;
            w_ctl.phase    = r_pass[0];
            w_ctl.swap_all = r_swap_all;
            if (w_last) begin
                n_state = S_IDLE;
                w_push  = 1'b1;
            end else begin
                n_pass = r_pass + CW'(1);
            end
        end else if (w_accept) begin
            w_push = 1'b1;
            case (olst_pkg::t_func'(i_cmd.func))
                olst_pkg::FN_PUSH_FRONT, olst_pkg::FN_PUSH_BACK: begin
                    if (w_full) begin
                        w_res.status = olst_pkg::STAT_FULL;
                    end else begin
                        w_ctl.op = olst_pkg::CELL_INS;
                        w_at     = (i_cmd.func == olst_pkg::FN_PUSH_FRONT) ? '0 : r_count;
                        n_count  = r_count + CW'(1);
                    end
                end
                olst_pkg::FN_POP_FRONT: begin
                    if (w_empty) begin
                        w_res.status = olst_pkg::STAT_SHORT;
                    end else begin
                        w_ctl.op = olst_pkg::CELL_DEL;
                        w_at     = '0;
                        n_count  = r_count - CW'(1);
                    end
                end
                olst_pkg::FN_POP_BACK: begin
                    if (w_empty) begin
                        w_res.status = olst_pkg::STAT_SHORT;
                    end else begin
                        n_count = r_count - CW'(1);
                    end
                end
                olst_pkg::FN_INSERT: begin
                    if ((i_cmd.position != '0) && w_pos_ge) begin
                        w_res.status = olst_pkg::STAT_RANGE;
                    end else if (w_full) begin
                        w_res.status = olst_pkg::STAT_FULL;
                    end else begin
                        w_ctl.op = olst_pkg::CELL_INS;
                        n_count  = r_count + CW'(1);
                    end
                end
                olst_pkg::FN_DELETE: begin
                    if (w_empty) begin
                        w_res.status = olst_pkg::STAT_SHORT;
                    end else if (w_pos_ge) begin
                        w_res.status = olst_pkg::STAT_RANGE;
                    end else begin
                        w_ctl.op = olst_pkg::CELL_DEL;
                        n_count  = r_count - CW'(1);
                    end
                end
                olst_pkg::FN_REVERSE: begin
                    if (r_count < CW'(2)) begin
                        w_res.status = olst_pkg::STAT_SHORT;
                    end else begin
                        w_push     = 1'b0;
                        n_state    = S_XCHG;
                        n_pass     = '0;
                        n_swap_all = 1'b1;
                    end
                end
                olst_pkg::FN_SORT: begin
                    if (w_empty) begin
                        w_res.status = olst_pkg::STAT_SHORT;
                    end else if (r_count != CW'(1)) begin
                        w_push     = 1'b0;
                        n_state    = S_XCHG;
                        n_pass     = '0;
                        n_swap_all = 1'b0;
                    end
                end
                olst_pkg::FN_UPDATE: begin
                    if (w_empty) begin
                        w_res.status = olst_pkg::STAT_SHORT;
                    end else if (w_pos_ge) begin
                        w_res.status = olst_pkg::STAT_RANGE;
                    end else begin
                        w_ctl.op = olst_pkg::CELL_WR;
                    end
                end
                olst_pkg::FN_SEARCH: begin
                    if (w_empty) begin
                        w_res.status = olst_pkg::STAT_SHORT;
                    end else begin
                        w_res.found = |i_match;
                    end
                end
                olst_pkg::FN_READ: begin
                    if (w_empty) begin
                        w_res.status = olst_pkg::STAT_SHORT;
                    end else if (w_pos_ge) begin
                        w_res.status = olst_pkg::STAT_RANGE;
                    end else begin
                        w_res.read_value = w_rd;
                    end
                end
                default: begin
                    w_res.status = olst_pkg::STAT_DONE;
                end
            endcase
        end
        w_res.entry_count = olst_pkg::CNT_OUT_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_pass     <= '0;
            r_swap_all <= 1'b0;
            r_out_v    <= 1'b0;
            r_skid_v   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_pass     <= n_pass;
            r_swap_all <= n_swap_all;
            if (w_push) begin
                if (!r_out_v || w_pop) begin
                    r_out   <= w_res;
                    r_out_v <= 1'b1;
                end else begin
                    r_skid   <= w_res;
                    r_skid_v <= 1'b1;
                end
            end else if (w_pop) begin
                r_out    <= r_skid;
                r_out_v  <= r_skid_v;
                r_skid_v <= 1'b0;
            end
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_count <= CAP_C)
        else $error("entry count above capacity");

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_skid_v |-> r_out_v)
        else $error("skid beat held while output empty");

    assert property (@(posedge i_clk) disable iff (!i_rst_n) w_push |-> !r_skid_v)
        else $error("result produced with no buffer room");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_XCHG) |=> (r_count == $past(r_count)))
        else $error("entry count changed during exchange passes");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_XCHG) |-> (r_pass < r_count))
        else $error("pass counter ran past entry count");

endmodule

### hw/rtl/ordered_list_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_engine
// Bounded ordered list of signed values held in a chain of slot cells.
// ----------------------------------------------------------------------------
// each result beat is registered from its command beat, except multi-entry reverse/sort
// throughput: one command per cycle while the result side keeps up
// reverse and sort of N >= 2 entries run one odd-even exchange pass per cycle
//   through the cell chain; no command is taken meanwhile
// reset clears the entry count and both channels; slot contents are not cleared
// ----------------------------------------------------------------------------
module ordered_list_engine #(
    parameter int CAPACITY = olst_pkg::CAPACITY
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    olst_cmd_if.sink    i_cmd,
    olst_res_if.source  o_res
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic signed [olst_pkg::DATA_W-1:0] w_data [CAPACITY];
    logic [CAPACITY-2:0]                w_gt;
    logic [CAPACITY-1:0]                w_match;
    olst_pkg::t_cell_ctl                w_ctl;
    logic [CW-1:0]                      w_at;
    logic [CW-1:0]                      w_count;

    olst_ctrl #(
        .CAPACITY (CAPACITY),
        .CW       (CW)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (i_cmd),
        .o_res   (o_res),
        .i_data  (w_data),
        .i_match (w_match),
        .o_ctl   (w_ctl),
        .o_at    (w_at),
        .o_count (w_count)
    );

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        if (g == 0) begin : g_head
            olst_cell #(
                .IDX (g),
                .CW  (CW)
            ) u_cell (
                .i_clk     (i_clk),
                .i_ctl     (w_ctl),
                .i_at      (w_at),
                .i_count   (w_count),
                .i_value   (i_cmd.value),
                .i_left    (i_cmd.value),
                .i_right   (w_data[g+1]),
                .i_gt_left (1'b0),
                .o_data    (w_data[g]),
                .o_gt      (w_gt[g]),
                .o_match   (w_match[g])
            );
        end else if (g == CAPACITY - 1) begin : g_tail
            olst_cell #(
                .IDX (g),
                .CW  (CW)
            ) u_cell (
                .i_clk     (i_clk),
                .i_ctl     (w_ctl),
                .i_at      (w_at),
                .i_count   (w_count),
                .i_value   (i_cmd.value),
                .i_left    (w_data[g-1]),
                .i_right   (w_data[g]),
                .i_gt_left (w_gt[g-1]),
                .o_data    (w_data[g]),
                .o_gt      (),
                .o_match   (w_match[g])
            );
        end else begin : g_mid
            olst_cell #(
                .IDX (g),
                .CW  (CW)
            ) u_cell (
                .i_clk     (i_clk),
                .i_ctl     (w_ctl),
                .i_at      (w_at),
                .i_count   (w_count),
                .i_value   (i_cmd.value),
                .i_left    (w_data[g-1]),
                .i_right   (w_data[g+1]),
                .i_gt_left (w_gt[g-1]),
                .o_data    (w_data[g]),
                .o_gt      (w_gt[g]),
                .o_match   (w_match[g])
            );
        end
    end

endmodule
